// ===== rtl/edf_realtime_task_scheduler_defines.svh =====
// Assertion macros for the EDF scheduler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef EDF_REALTIME_TASK_SCHEDULER_DEFINES_SVH
`define EDF_REALTIME_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define EDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/edf_pkg.sv =====
// Shared types and constants for the EDF scheduler.
// No dependencies.
package edf_pkg;

  localparam int MAX_RT_TASKS    = 16;
  localparam int MAX_PLAIN_TASKS = 16;
  localparam int TASK_ID_BITS    = 8;
  localparam int RT_CNT_W        = $clog2(MAX_RT_TASKS + 1);
  localparam int PL_CNT_W        = $clog2(MAX_PLAIN_TASKS + 1);

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAIN  = 3'd1;
  localparam logic [2:0] OP_RT     = 3'd2;
  localparam logic [2:0] OP_YIELD  = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_SELECTED = 3'd1;
  localparam logic [2:0] ST_WAITING  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_REL, S_SETTLE, S_PICK, S_OUT
  } state_t;

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] id;
    logic [31:0]             key;
    logic [31:0]             aux;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic sorted;
  } cmd_t;

endpackage

// ===== rtl/edf_cell.sv =====
// One slot of a task table: a sorted/append shift-register cell.
// Depends on edf_pkg.
module edf_cell (
  input  logic          clk,
  input  edf_pkg::cmd_t   cmd,
  input  edf_pkg::entry_t new_e,
  input  edf_pkg::entry_t left_e,
  input  edf_pkg::entry_t right_e,
  input  logic          valid,
  input  logic          left_gt,
  output logic          gt,
  output edf_pkg::entry_t q
);

  edf_pkg::entry_t entry_r, entry_nxt;

  // slot is free or holds a strictly later key: new entry lands here or before
  assign gt = !valid || (cmd.sorted && (entry_r.key > new_e.key));
  assign q  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.pop) begin
      entry_nxt = right_e;
    end else if (cmd.ins) begin
      if (left_gt) begin
        entry_nxt = left_e;
      end else if (gt) begin
        entry_nxt = new_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/edf_realtime_task_scheduler.sv =====
// EDF real-time task scheduler top level: sequencer, clock, counters, three task tables.
// Depends on edf_pkg, edf_cell and edf_realtime_task_scheduler_defines.svh.
//
// Use: one command per in_ transaction (tick, create plain, create real-time, yield,
// finish); exactly one result per command on the out_ channel.
// Tables are chains of cells; a removal shifts every cell toward the head, and an
// insert shifts the cells behind the insertion point. Tick, create and undefined
// ops pass through EXEC and OUT; yield/finish pass through EXEC, REL, SETTLE, PICK
// and OUT (PICK skipped for a refused yield), REL moving due tasks from the release
// table (0 to 16), one per cycle, into the ready chain. in_tready is high only while
// the sequencer is idle: one command at a time, the next taken after OUT is left.
// The result sits in an output register; the next command is accepted while it
// waits. A stalled out_tready holds the register, and a further result waits in
// the sequencer until the register frees.
// Reset (rst_n low, synchronous) clears the clock, counts, running task and
// totals; table slots need no clearing since only slots below a count are read.
`include "edf_realtime_task_scheduler_defines.svh"
module edf_realtime_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // op[2:0], task_id[10:3], start_ms[42:11], rel_deadline_ms[74:43]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[2:0], selected_task[10:3], met[26:11], missed[42:27]
);

  localparam int NR = edf_pkg::MAX_RT_TASKS;
  localparam int NP = edf_pkg::MAX_PLAIN_TASKS;
  localparam int IW = edf_pkg::TASK_ID_BITS;
  localparam int RW = edf_pkg::RT_CNT_W;
  localparam int PW = edf_pkg::PL_CNT_W;

  edf_pkg::state_t state_r, state_nxt;

  logic [2:0]    op_r, op_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [31:0]   st_r, st_nxt;
  logic [31:0]   rel_r, rel_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [RW-1:0] rdy_cnt_r, rdy_cnt_nxt;
  logic [RW-1:0] rls_cnt_r, rls_cnt_nxt;
  logic [PW-1:0] pl_cnt_r, pl_cnt_nxt;
  logic [IW-1:0] run_id_r, run_id_nxt;
  logic          run_valid_r, run_valid_nxt;
  logic          run_rt_r, run_rt_nxt;
  logic [31:0]   run_dl_r, run_dl_nxt;
  logic [15:0]   met_r, met_nxt;
  logic [15:0]   missed_r, missed_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [IW-1:0] res_sel_r, res_sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_sel_r, out_sel_nxt;
  logic [15:0]   out_met_r, out_met_nxt;
  logic [15:0]   out_missed_r, out_missed_nxt;

  edf_pkg::cmd_t   rdy_cmd, rls_cmd, pl_cmd;
  edf_pkg::entry_t rdy_new, rls_new, pl_new;
  edf_pkg::entry_t rdy_q [NR];
  edf_pkg::entry_t rls_q [NR];
  edf_pkg::entry_t pl_q  [NP];
  edf_pkg::entry_t rdy_ext [NR+2];
  edf_pkg::entry_t rls_ext [NR+2];
  edf_pkg::entry_t pl_ext  [NP+2];
  logic rdy_gtc [NR+1];
  logic rls_gtc [NR+1];
  logic pl_gtc  [NP+1];

  logic        rdy_full, rls_full, pl_full, rls_move, refused;
  logic [32:0] dl_sum;
  logic [31:0] dl_sat;
  logic        out_free;

  assign rdy_full = (rdy_cnt_r == RW'(NR));
  assign rls_full = (rls_cnt_r == RW'(NR));
  assign pl_full  = (pl_cnt_r == PW'(NP));
  assign rls_move = (rls_cnt_r != '0) && (rls_q[0].key <= now_r) && !rdy_full;
  assign refused  = run_valid_r && (op_r == edf_pkg::OP_YIELD) &&
                    (run_rt_r ? rdy_full : pl_full);
  assign dl_sum   = {1'b0, st_r} + {1'b0, rel_r};
  assign dl_sat   = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == edf_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_missed_r, out_met_r, out_sel_r, out_status_r};

  // cell chains
  assign rdy_gtc[0]      = 1'b0;
  assign rls_gtc[0]      = 1'b0;
  assign pl_gtc[0]       = 1'b0;
  assign rdy_ext[0]      = rdy_new;
  assign rls_ext[0]      = rls_new;
  assign pl_ext[0]       = pl_new;
  assign rdy_ext[NR+1]   = rdy_q[NR-1];
  assign rls_ext[NR+1]   = rls_q[NR-1];
  assign pl_ext[NP+1]    = pl_q[NP-1];

  for (genvar i = 0; i < NR; i++) begin : g_rt
    assign rdy_ext[i+1] = rdy_q[i];
    assign rls_ext[i+1] = rls_q[i];
    edf_cell u_rdy (
      .clk(clk), .cmd(rdy_cmd), .new_e(rdy_new), .left_e(rdy_ext[i]),
      .right_e(rdy_ext[i+2]), .valid(RW'(i) < rdy_cnt_r), .left_gt(rdy_gtc[i]),
      .gt(rdy_gtc[i+1]), .q(rdy_q[i])
    );
    edf_cell u_rls (
      .clk(clk), .cmd(rls_cmd), .new_e(rls_new), .left_e(rls_ext[i]),
      .right_e(rls_ext[i+2]), .valid(RW'(i) < rls_cnt_r), .left_gt(rls_gtc[i]),
      .gt(rls_gtc[i+1]), .q(rls_q[i])
    );
  end

  for (genvar i = 0; i < NP; i++) begin : g_pl
    assign pl_ext[i+1] = pl_q[i];
    edf_cell u_pl (
      .clk(clk), .cmd(pl_cmd), .new_e(pl_new), .left_e(pl_ext[i]),
      .right_e(pl_ext[i+2]), .valid(PW'(i) < pl_cnt_r), .left_gt(pl_gtc[i]),
      .gt(pl_gtc[i+1]), .q(pl_q[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edf_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = edf_pkg::S_EXEC;
      end
      edf_pkg::S_EXEC: begin
        if (op_r == edf_pkg::OP_YIELD || op_r == edf_pkg::OP_FINISH) begin
          state_nxt = edf_pkg::S_REL;
        end else begin
          state_nxt = edf_pkg::S_OUT;
        end
      end
      edf_pkg::S_REL: begin
        if (!rls_move) state_nxt = edf_pkg::S_SETTLE;
      end
      edf_pkg::S_SETTLE: begin
        state_nxt = refused ? edf_pkg::S_OUT : edf_pkg::S_PICK;
      end
      edf_pkg::S_PICK: state_nxt = edf_pkg::S_OUT;
      edf_pkg::S_OUT: begin
        if (out_free) state_nxt = edf_pkg::S_IDLE;
      end
      default: state_nxt = edf_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    st_nxt         = st_r;
    rel_nxt        = rel_r;
    now_nxt        = now_r;
    rdy_cnt_nxt    = rdy_cnt_r;
    rls_cnt_nxt    = rls_cnt_r;
    pl_cnt_nxt     = pl_cnt_r;
    run_id_nxt     = run_id_r;
    run_valid_nxt  = run_valid_r;
    run_rt_nxt     = run_rt_r;
    run_dl_nxt     = run_dl_r;
    met_nxt        = met_r;
    missed_nxt     = missed_r;
    res_status_nxt = res_status_r;
    res_sel_nxt    = res_sel_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_sel_nxt    = out_sel_r;
    out_met_nxt    = out_met_r;
    out_missed_nxt = out_missed_r;
    rdy_cmd        = '0;
    rls_cmd        = '0;
    pl_cmd         = '0;
    rdy_new        = '0;
    rls_new        = '0;
    pl_new         = '0;
    rdy_cmd.sorted = 1'b1;
    rls_cmd.sorted = 1'b1;

    unique case (state_r)
      edf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tdata[2:0];
          id_nxt  = IW'(in_tdata[10:3]);
          st_nxt  = in_tdata[42:11];
          rel_nxt = in_tdata[74:43];
        end
      end
      edf_pkg::S_EXEC: begin
        res_status_nxt = edf_pkg::ST_ACCEPTED;
        res_sel_nxt    = '0;
        case (op_r)
          edf_pkg::OP_TICK: begin
            if (now_r != 32'hFFFF_FFFF) now_nxt = now_r + 32'd1;
          end
          edf_pkg::OP_PLAIN: begin
            if (pl_full) begin
              res_status_nxt = edf_pkg::ST_FULL;
            end else begin
              pl_cmd.ins = 1'b1;
              pl_new.id  = id_r;
              pl_cnt_nxt = pl_cnt_r + PW'(1);
            end
          end
          edf_pkg::OP_RT: begin
            if (st_r < now_r) begin
              if (rdy_full) begin
                res_status_nxt = edf_pkg::ST_FULL;
              end else begin
                rdy_cmd.ins = 1'b1;
                rdy_new.id  = id_r;
                rdy_new.key = dl_sat;
                rdy_cnt_nxt = rdy_cnt_r + RW'(1);
              end
            end else begin
              if (rls_full) begin
                res_status_nxt = edf_pkg::ST_FULL;
              end else begin
                rls_cmd.ins = 1'b1;
                rls_new.id  = id_r;
                rls_new.key = st_r;
                rls_new.aux = dl_sat;
                rls_cnt_nxt = rls_cnt_r + RW'(1);
              end
            end
          end
          default: ;
        endcase
      end
      edf_pkg::S_REL: begin
        if (rls_move) begin
          rls_cmd.pop = 1'b1;
          rls_cnt_nxt = rls_cnt_r - RW'(1);
          rdy_cmd.ins = 1'b1;
          rdy_new.id  = rls_q[0].id;
          rdy_new.key = rls_q[0].aux;
          rdy_cnt_nxt = rdy_cnt_r + RW'(1);
        end
      end
      edf_pkg::S_SETTLE: begin
        if (refused) begin
          res_status_nxt = edf_pkg::ST_FULL;
        end else if (run_valid_r) begin
          if (op_r == edf_pkg::OP_YIELD) begin
            if (run_rt_r) begin
              rdy_cmd.ins = 1'b1;
              rdy_new.id  = run_id_r;
              rdy_new.key = run_dl_r;
              rdy_cnt_nxt = rdy_cnt_r + RW'(1);
            end else begin
              pl_cmd.ins = 1'b1;
              pl_new.id  = run_id_r;
              pl_cnt_nxt = pl_cnt_r + PW'(1);
            end
          end else if (run_rt_r) begin
            if (run_dl_r < now_r) begin
              if (missed_r != 16'hFFFF) missed_nxt = missed_r + 16'd1;
            end else begin
              if (met_r != 16'hFFFF) met_nxt = met_r + 16'd1;
            end
          end
        end
      end
      edf_pkg::S_PICK: begin
        run_valid_nxt = 1'b0;
        run_rt_nxt    = 1'b0;
        run_dl_nxt    = '0;
        run_id_nxt    = '0;
        res_sel_nxt   = '0;
        if (rdy_cnt_r != '0) begin
          rdy_cmd.pop    = 1'b1;
          rdy_cnt_nxt    = rdy_cnt_r - RW'(1);
          run_valid_nxt  = 1'b1;
          run_rt_nxt     = 1'b1;
          run_id_nxt     = rdy_q[0].id;
          run_dl_nxt     = rdy_q[0].key;
          res_status_nxt = edf_pkg::ST_SELECTED;
          res_sel_nxt    = rdy_q[0].id;
        end else if (pl_cnt_r != '0) begin
          pl_cmd.pop     = 1'b1;
          pl_cnt_nxt     = pl_cnt_r - PW'(1);
          run_valid_nxt  = 1'b1;
          run_id_nxt     = pl_q[0].id;
          res_status_nxt = edf_pkg::ST_SELECTED;
          res_sel_nxt    = pl_q[0].id;
        end else begin
          res_status_nxt = (rls_cnt_r != '0) ? edf_pkg::ST_WAITING : edf_pkg::ST_EMPTY;
        end
      end
      edf_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_sel_nxt    = 8'(res_sel_r);
          out_met_nxt    = met_r;
          out_missed_nxt = missed_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edf_pkg::S_IDLE;
      now_r       <= '0;
      rdy_cnt_r   <= '0;
      rls_cnt_r   <= '0;
      pl_cnt_r    <= '0;
      run_id_r    <= '0;
      run_valid_r <= 1'b0;
      run_rt_r    <= 1'b0;
      run_dl_r    <= '0;
      met_r       <= '0;
      missed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      rdy_cnt_r   <= rdy_cnt_nxt;
      rls_cnt_r   <= rls_cnt_nxt;
      pl_cnt_r    <= pl_cnt_nxt;
      run_id_r    <= run_id_nxt;
      run_valid_r <= run_valid_nxt;
      run_rt_r    <= run_rt_nxt;
      run_dl_r    <= run_dl_nxt;
      met_r       <= met_nxt;
      missed_r    <= missed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    st_r         <= st_nxt;
    rel_r        <= rel_nxt;
    res_status_r <= res_status_nxt;
    res_sel_r    <= res_sel_nxt;
    out_status_r <= out_status_nxt;
    out_sel_r    <= out_sel_nxt;
    out_met_r    <= out_met_nxt;
    out_missed_r <= out_missed_nxt;
  end

  `EDF_ASSERT_IMP(a_counts_bounded, clk, rst_n, 1'b1,
    (rdy_cnt_r <= RW'(NR)) && (rls_cnt_r <= RW'(NR)) && (pl_cnt_r <= PW'(NP)),
    "table count above capacity")
  `EDF_ASSERT_IMP(a_insert_has_room, clk, rst_n,
    rdy_cmd.ins || rls_cmd.ins || pl_cmd.ins,
    (!rdy_cmd.ins || rdy_gtc[NR]) && (!rls_cmd.ins || rls_gtc[NR]) && (!pl_cmd.ins || pl_gtc[NP]),
    "insert into a full chain")
  `EDF_ASSERT_IMP(a_ready_sorted, clk, rst_n, rdy_cnt_r >= RW'(2),
    rdy_q[0].key <= rdy_q[1].key, "ready table head out of deadline order")
  `EDF_ASSERT_NXT(a_release_moves_one, clk, rst_n,
    (state_r == edf_pkg::S_REL) && rls_move,
    (rdy_cnt_r == $past(rdy_cnt_r) + RW'(1)) && (rls_cnt_r == $past(rls_cnt_r) - RW'(1)),
    "release step did not move exactly one task")
  `EDF_ASSERT_NXT(a_pick_runs_rt, clk, rst_n,
    (state_r == edf_pkg::S_PICK) && (rdy_cnt_r != '0),
    run_valid_r && run_rt_r && (res_status_r == edf_pkg::ST_SELECTED),
    "ready task not selected first")

endmodule
